/* design/lph_pkg.sv */
// Shared constants and controller/datapath signal groups for the hash table.
package lph_pkg;

  localparam int KEY_W = 31;
  localparam int VAL_W = 32;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_TOMB  = 2'd1;
  localparam logic [1:0] MARK_USED  = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic       clr_step;
    logic       load;
    logic       rem_step;
    logic       probe_start;
    logic       probe_next;
    logic       ins_write;
    logic       tomb_write;
    logic       res_set;
    logic [1:0] res_code;
    logic       res_take;
    logic       out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic       rem_done;
    logic [1:0] opcode;
    logic [1:0] mark;
    logic       key_eq;
    logic       probe_last;
    logic       out_free;
  } dp_stat_t;

endpackage

/* design/lph_req_if.sv */
// Request channel: opcode, key and value with valid/ready.
interface lph_req_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       opcode;
  logic [lph_pkg::KEY_W-1:0]        key;
  logic signed [lph_pkg::VAL_W-1:0] value;

  modport source (output valid, output opcode, output key, output value, input ready);
  modport sink   (input valid, input opcode, input key, input value, output ready);
endinterface

/* design/lph_rsp_if.sv */
// Response channel: status and read value with valid/ready.
interface lph_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       status;
  logic signed [lph_pkg::VAL_W-1:0] read_value;

  modport source (output valid, output status, output read_value, input ready);
  modport sink   (input valid, input status, input read_value, output ready);
endinterface

/* design/linear_probe_hash_table.sv */
// Top level of the linear-probing hash table: controller plus datapath.
//
//   channel  dir  fields                     transfer when
//   req      in   opcode, key, value         req.valid && req.ready
//   rsp      out  status, read_value         rsp.valid && rsp.ready
//
// Each item runs: accept, reduction, probe start, probe of 1..TABLE_SLOTS slots, result hand-off.
// Reduction takes the low index bits when TABLE_SLOTS is a power of two, else a reciprocal
// multiply, then multiply-subtract. The probe reads one slot per cycle from the slot memory.
// After reset a clearing pass marks every slot empty;
// req.ready stays low meanwhile.
// A finished result waits in the output register; the next request is taken meanwhile,
// and its result is held back until the previous transfer on rsp completes.
module linear_probe_hash_table #(
  parameter int TABLE_SLOTS = 16
) (
  input logic       clk,
  input logic       rst,
  lph_req_if.sink   req,
  lph_rsp_if.source rsp
);

  lph_pkg::ctrl_cmd_t cmd;
  lph_pkg::dp_stat_t  stat;

  lph_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .stat (stat),
    .cmd  (cmd)
  );

  lph_dp #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rsp  (rsp),
    .cmd  (cmd),
    .stat (stat)
  );

endmodule

/* design/lph_dp.sv */
// Datapath: slot memories, home-slot remainder unit, probe pointer and result registers.
module lph_dp #(
  parameter int TABLE_SLOTS = 16
) (
  input  logic                clk,
  input  logic                rst,
  lph_req_if.sink             req,
  lph_rsp_if.source           rsp,
  input  lph_pkg::ctrl_cmd_t  cmd,
  output lph_pkg::dp_stat_t   stat
);

  localparam int IDX_W = $clog2(TABLE_SLOTS);
  localparam int CNT_W = 2;
  localparam bit IS_POW2 = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);
  localparam logic [CNT_W-1:0] REM_STEPS = CNT_W'(2);
  localparam int RECIP_W  = 32;
  localparam int PROD_W   = lph_pkg::KEY_W + RECIP_W;
  localparam int RECIP_SH = lph_pkg::KEY_W + IDX_W;
  localparam logic [63:0] RECIP_POW  = 64'd1 << RECIP_SH;
  localparam logic [63:0] RECIP_FULL = (RECIP_POW + 64'(TABLE_SLOTS - 1)) / 64'(TABLE_SLOTS);
  localparam logic [RECIP_W-1:0]        RECIP   = RECIP_FULL[RECIP_W-1:0];
  localparam logic [lph_pkg::KEY_W-1:0] SLOTS_K = TABLE_SLOTS[lph_pkg::KEY_W-1:0];

  logic [1:0]                       mark_mem  [TABLE_SLOTS];
  logic [lph_pkg::KEY_W-1:0]        key_mem   [TABLE_SLOTS];
  logic signed [lph_pkg::VAL_W-1:0] value_mem [TABLE_SLOTS];

  logic [1:0]                       opcode;
  logic [lph_pkg::KEY_W-1:0]        key;
  logic signed [lph_pkg::VAL_W-1:0] value;
  logic [PROD_W-1:0]                prod;
  logic [IDX_W-1:0]                 rem;
  logic [CNT_W-1:0]                 rem_cnt;
  logic [IDX_W-1:0]                 probe_idx;
  logic [IDX_W-1:0]                 probe_cnt;
  logic [IDX_W-1:0]                 clr_idx;
  logic [1:0]                       rd_mark;
  logic [lph_pkg::KEY_W-1:0]        rd_key;
  logic signed [lph_pkg::VAL_W-1:0] rd_value;
  logic [1:0]                       res_status;
  logic signed [lph_pkg::VAL_W-1:0] res_value;
  logic                             out_valid;
  logic [1:0]                       out_status;
  logic signed [lph_pkg::VAL_W-1:0] out_value;

  logic [PROD_W-1:0]         prod_sh;
  logic [lph_pkg::KEY_W-1:0] quot;
  logic [lph_pkg::KEY_W-1:0] quot_slots;
  logic [lph_pkg::KEY_W-1:0] key_rem;
  logic [IDX_W-1:0]          home;
  logic [IDX_W-1:0]          idx_next;
  logic [IDX_W-1:0]          rd_addr;

  // key / slots by rounded-up reciprocal: exact for every 31-bit key; product registered,
  // the multiply-subtract lands in the second step
  assign prod_sh    = prod >> RECIP_SH;
  assign quot       = prod_sh[lph_pkg::KEY_W-1:0];
  assign quot_slots = quot * SLOTS_K;
  assign key_rem    = key - quot_slots;
  assign home       = IS_POW2 ? key[IDX_W-1:0] : rem;
  assign idx_next   = (probe_idx == LAST_IDX) ? '0 : probe_idx + 1'b1;
  assign rd_addr    = cmd.probe_start ? home : idx_next;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      opcode <= req.opcode;
      key    <= req.key;
      value  <= req.value;
      rem    <= '0;
    end else if (cmd.rem_step) begin
      prod <= PROD_W'(key) * PROD_W'(RECIP);
      rem  <= key_rem[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem_cnt <= '0;
    end else if (cmd.load) begin
      rem_cnt <= REM_STEPS;
    end else if (cmd.rem_step) begin
      rem_cnt <= rem_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_idx <= '0;
      probe_cnt <= '0;
    end else if (cmd.probe_start) begin
      probe_idx <= home;
      probe_cnt <= '0;
    end else if (cmd.probe_next) begin
      probe_idx <= idx_next;
      probe_cnt <= probe_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clr_step) begin
      clr_idx <= (clr_idx == LAST_IDX) ? '0 : clr_idx + 1'b1;
    end
  end

  // slot store: one write port, one registered read port; read runs one slot ahead
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      mark_mem[clr_idx] <= lph_pkg::MARK_EMPTY;
    end else if (cmd.ins_write) begin
      mark_mem[probe_idx] <= lph_pkg::MARK_USED;
    end else if (cmd.tomb_write) begin
      mark_mem[probe_idx] <= lph_pkg::MARK_TOMB;
    end
    if (cmd.ins_write) begin
      key_mem[probe_idx]   <= key;
      value_mem[probe_idx] <= value;
    end
    rd_mark  <= mark_mem[rd_addr];
    rd_key   <= key_mem[rd_addr];
    rd_value <= value_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      res_status <= cmd.res_code;
      res_value  <= cmd.res_take ? rd_value : '0;
    end
    if (cmd.out_load) begin
      out_status <= res_status;
      out_value  <= res_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.read_value = out_value;

  assign stat.clr_last   = (clr_idx == LAST_IDX);
  assign stat.rem_done   = IS_POW2 || (rem_cnt == CNT_W'(1));
  assign stat.opcode     = opcode;
  assign stat.mark       = rd_mark;
  assign stat.key_eq     = (rd_key == key);
  assign stat.probe_last = (probe_cnt == LAST_IDX);
  assign stat.out_free   = !out_valid || rsp.ready;

  a_ins_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.ins_write |-> rd_mark != lph_pkg::MARK_USED)
    else $error("insert overwrote an occupied slot");

  a_tomb_on_match: assert property (@(posedge clk) disable iff (rst)
    cmd.tomb_write |-> (rd_mark == lph_pkg::MARK_USED) && (rd_key == key))
    else $error("tombstone written on a slot that does not hold the key");

  a_out_no_overrun: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || rsp.ready))
    else $error("result loaded over an untaken result");

  a_out_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("loaded result not presented");

endmodule

/* design/lph_ctrl.sv */
// Controller: clearing pass, home-slot reduction, probe sequencing and result hand-off.
module lph_ctrl (
  input  logic                clk,
  input  logic                rst,
  lph_req_if.sink             req,
  input  lph_pkg::dp_stat_t   stat,
  output lph_pkg::ctrl_cmd_t  cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MOD   = 3'd2;
  localparam logic [2:0] S_START = 3'd3;
  localparam logic [2:0] S_PROBE = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       hit;
  logic       op_valid;

  assign hit      = (stat.mark == lph_pkg::MARK_USED) && stat.key_eq;
  assign op_valid = (stat.opcode == lph_pkg::OP_INSERT) || (stat.opcode == lph_pkg::OP_DELETE)
                    || (stat.opcode == lph_pkg::OP_LOOKUP);
  assign req.ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req.valid) begin
          cmd.load   = 1'b1;
          state_next = S_MOD;
        end
      end
      S_MOD: begin
        cmd.rem_step = 1'b1;
        if (stat.rem_done) state_next = S_START;
      end
      S_START: begin
        cmd.probe_start = 1'b1;
        if (op_valid) begin
          state_next = S_PROBE;
        end else begin
          cmd.res_set  = 1'b1;
          cmd.res_code = lph_pkg::ST_MISS;
          state_next   = S_DONE;
        end
      end
      S_PROBE: begin
        if (stat.opcode == lph_pkg::OP_INSERT) begin
          if (stat.mark != lph_pkg::MARK_USED) begin
            cmd.ins_write = 1'b1;
            cmd.res_set   = 1'b1;
            cmd.res_code  = lph_pkg::ST_OK;
            state_next    = S_DONE;
          end else if (stat.probe_last) begin
            cmd.res_set  = 1'b1;
            cmd.res_code = lph_pkg::ST_FULL;
            state_next   = S_DONE;
          end else begin
            cmd.probe_next = 1'b1;
          end
        end else begin
          if (stat.mark == lph_pkg::MARK_EMPTY) begin
            cmd.res_set  = 1'b1;
            cmd.res_code = lph_pkg::ST_MISS;
            state_next   = S_DONE;
          end else if (hit) begin
            cmd.tomb_write = (stat.opcode == lph_pkg::OP_DELETE);
            cmd.res_take   = (stat.opcode == lph_pkg::OP_LOOKUP);
            cmd.res_set    = 1'b1;
            cmd.res_code   = lph_pkg::ST_OK;
            state_next     = S_DONE;
          end else if (stat.probe_last) begin
            cmd.res_set  = 1'b1;
            cmd.res_code = lph_pkg::ST_MISS;
            state_next   = S_DONE;
          end else begin
            cmd.probe_next = 1'b1;
          end
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> state == S_MOD)
    else $error("accepted transfer did not start the home-slot reduction");

  a_probe_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE && stat.probe_last) |=> state != S_PROBE)
    else $error("probe ran past the last slot");

  a_one_write: assert property (@(posedge clk) disable iff (rst)
    !(cmd.ins_write && cmd.tomb_write))
    else $error("insert and delete wrote the same cycle");

endmodule

/* bench/hash_table_checker.sv */
// Watches both channels, predicts each result from a shadow of the slot store and compares.
`timescale 1ns / 1ps

module hash_table_checker #(
  parameter int SLOTS = 16
) (
  input  logic clk,
  input  logic rst,
  lph_req_if   req,
  lph_rsp_if   rsp,
  output int   mismatches,
  output int   pending
);

  typedef struct packed {
    logic [1:0]                       status;
    logic signed [lph_pkg::VAL_W-1:0] read_value;
  } table_result_t;

  logic [1:0]                       slot_state [SLOTS];
  logic [lph_pkg::KEY_W-1:0]        slot_keys  [SLOTS];
  logic signed [lph_pkg::VAL_W-1:0] slot_vals  [SLOTS];

  table_result_t expected_results [$];

  // first occupied slot holding k on its probe path, -1 if none
  function automatic int locate_key(input logic [lph_pkg::KEY_W-1:0] k);
    int slot;
    int hit;
    slot = int'(k % SLOTS);
    hit  = -1;
    for (int n = 0; n < SLOTS; n++) begin
      if (slot_state[slot] == lph_pkg::MARK_EMPTY) break;
      if (slot_state[slot] == lph_pkg::MARK_USED && slot_keys[slot] == k) begin
        hit = slot;
        break;
      end
      slot = (slot + 1) % SLOTS;
    end
    return hit;
  endfunction

  function automatic table_result_t apply_request(input logic [1:0] op,
                                                  input logic [lph_pkg::KEY_W-1:0] k,
                                                  input logic signed [lph_pkg::VAL_W-1:0] v);
    table_result_t r;
    int slot;
    int hit;
    r.status     = lph_pkg::ST_MISS;
    r.read_value = '0;
    slot = int'(k % SLOTS);
    case (op)
      lph_pkg::OP_INSERT: begin
        // tombstones are reusable; no duplicate check
        r.status = lph_pkg::ST_FULL;
        for (int n = 0; n < SLOTS; n++) begin
          if (slot_state[slot] != lph_pkg::MARK_USED) begin
            slot_keys[slot]  = k;
            slot_vals[slot]  = v;
            slot_state[slot] = lph_pkg::MARK_USED;
            r.status = lph_pkg::ST_OK;
            break;
          end
          slot = (slot + 1) % SLOTS;
        end
      end
      lph_pkg::OP_DELETE: begin
        hit = locate_key(k);
        if (hit >= 0) begin
          slot_state[hit] = lph_pkg::MARK_TOMB;
          r.status = lph_pkg::ST_OK;
        end
      end
      lph_pkg::OP_LOOKUP: begin
        hit = locate_key(k);
        if (hit >= 0) begin
          r.status     = lph_pkg::ST_OK;
          r.read_value = slot_vals[hit];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    table_result_t want;
    if (rst) begin
      for (int n = 0; n < SLOTS; n++) slot_state[n] = lph_pkg::MARK_EMPTY;
      expected_results.delete();
    end else begin
      // compare before predicting: a result never belongs to the request taken at the same edge
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: status %0d, read_value %0d", rsp.status, rsp.read_value);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            mismatches++;
          end
          if (rsp.read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value, rsp.read_value);
            mismatches++;
          end
        end
      end
      if (req.valid && req.ready)
        expected_results.push_back(apply_request(req.opcode, req.key, req.value));
    end
    pending <= expected_results.size();
  end

endmodule

/* bench/linear_probe_hash_table_test.sv */
// Stimulus, flow control and verdict for the linear-probing hash table.
`timescale 1ns / 1ps

module linear_probe_hash_table_test;

  localparam int TABLE_SLOTS  = 16;
  localparam int RANDOM_ITEMS = 1725;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 2 * TABLE_SLOTS + 16;
  localparam int POOL_DEPTH   = 24;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int RX_ALWAYS = 0;
  localparam int RX_COIN   = 1;
  localparam int RX_SPARSE = 2;
  localparam int RX_BEAT   = 3;

  typedef logic [lph_pkg::KEY_W-1:0] key_t;

  logic clk = 1'b0;
  logic rst;

  lph_req_if req_ch ();
  lph_rsp_if rsp_ch ();

  int mismatches;
  int pending;

  linear_probe_hash_table #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  hash_table_checker #(
    .SLOTS(TABLE_SLOTS)
  ) table_check (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .mismatches(mismatches),
    .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: stall pattern of its own, plus one long hold-off on request
  logic hold_req  = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;
  int   rx_mode   = RX_ALWAYS;
  int   rx_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen    <= hold_req;
      hold_left    <= HOLD_CYCLES;
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= $urandom_range(RX_ALWAYS, RX_BEAT);
        rx_left <= $urandom_range(20, 200);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        RX_ALWAYS: rsp_ch.ready <= 1'b1;
        RX_COIN:   rsp_ch.ready <= $urandom_range(0, 1);
        RX_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        default:   rsp_ch.ready <= ((rx_left % 5) < 2);
      endcase
    end
  end

  // watchdog: cycles without any transfer
  int idle_count = 0;

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_count <= 0;
    end else if (idle_count >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  // sender state
  int   burst_left = 0;
  bit   gapless    = 1'b0;
  key_t known_keys [$];

  task automatic pause_sender(input int n);
    if (n > 0) begin
      req_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // valid stays high after the transfer; pause_sender lowers it when a gap follows
  task automatic issue(input logic [1:0] op, input key_t k,
                       input logic signed [lph_pkg::VAL_W-1:0] v);
    if (burst_left == 0) begin
      pause_sender(gapless ? 0 : $urandom_range(1, 12));
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    req_ch.valid  <= 1'b1;
    req_ch.opcode <= op;
    req_ch.key    <= k;
    req_ch.value  <= v;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    if (op == lph_pkg::OP_INSERT) begin
      known_keys.push_back(k);
      if (known_keys.size() > POOL_DEPTH) void'(known_keys.pop_front());
    end
  endtask

  function automatic key_t fresh_key();
    // small keys pile up on few home slots; wide ones toggle every bit
    if ($urandom_range(0, 1)) return key_t'($urandom);
    return key_t'($urandom_range(0, 63));
  endfunction

  initial begin
    int                               insert_weight;
    int                               pick;
    logic [1:0]                       op;
    key_t                             k;
    logic signed [lph_pkg::VAL_W-1:0] v;

    rst           <= 1'b1;
    req_ch.valid  <= 1'b0;
    req_ch.opcode <= lph_pkg::OP_INSERT;
    req_ch.key    <= '0;
    req_ch.value  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // empty table: misses and the unused opcode
    issue(lph_pkg::OP_LOOKUP, 31'd7, 32'sd0);
    issue(lph_pkg::OP_DELETE, 31'd7, 32'sd0);
    issue(OP_UNUSED, 31'h7FFFFFFF, 32'hFFFFFFFF);
    // collisions on slot 0, a duplicate key, wrap slot with extreme key
    issue(lph_pkg::OP_INSERT, 31'd0, 32'h7FFFFFFF);
    issue(lph_pkg::OP_INSERT, 31'd16, 32'h80000000);
    issue(lph_pkg::OP_INSERT, 31'd0, 32'sd5);
    issue(lph_pkg::OP_INSERT, 31'h7FFFFFFF, 32'hFFFFFFFF);
    issue(lph_pkg::OP_LOOKUP, 31'd16, 32'sd0);
    // tombstone: lookup passes it and finds the duplicate, insert reuses it
    issue(lph_pkg::OP_DELETE, 31'd0, 32'sd0);
    issue(lph_pkg::OP_LOOKUP, 31'd0, 32'sd0);
    issue(lph_pkg::OP_INSERT, 31'd32, 32'sd0);
    // fill the remaining slots, then overflow and a full-length miss
    for (int i = 3; i < 15; i++)
      issue(lph_pkg::OP_INSERT, {27'($urandom), 4'(i)}, 32'($urandom));
    issue(lph_pkg::OP_INSERT, 31'd64, 32'sd1);
    issue(lph_pkg::OP_LOOKUP, 31'd48, 32'sd0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) begin
        insert_weight = $urandom_range(15, 70);
        gapless       = ($urandom_range(0, 3) == 0);
        if (i == 800) begin
          // keep offering while the receiver holds off
          gapless = 1'b1;
          hold_req <= ~hold_req;
        end
      end
      pick = $urandom_range(0, 99);
      if (pick < 3)
        op = OP_UNUSED;
      else if (pick < 3 + insert_weight)
        op = lph_pkg::OP_INSERT;
      else if (pick < 3 + insert_weight + (97 - insert_weight) / 2)
        op = lph_pkg::OP_DELETE;
      else
        op = lph_pkg::OP_LOOKUP;
      if (known_keys.size() > 0 &&
          $urandom_range(0, 9) < ((op == lph_pkg::OP_INSERT) ? 4 : 7))
        k = known_keys[$urandom_range(0, known_keys.size() - 1)];
      else
        k = fresh_key();
      case ($urandom_range(0, 15))
        0:       v = 32'h80000000;
        1:       v = 32'h7FFFFFFF;
        default: v = 32'($urandom);
      endcase
      issue(op, k, v);
    end
    req_ch.valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

/* files.f */
design/lph_pkg.sv
design/lph_req_if.sv
design/lph_rsp_if.sv
design/lph_dp.sv
design/lph_ctrl.sv
design/linear_probe_hash_table.sv
bench/hash_table_checker.sv
bench/linear_probe_hash_table_test.sv
